// ----- design/aled_pkg.sv -----
package aled_pkg;

    // Largest strip the pixel store is built for, unless the top level is told otherwise.
    localparam int DEFAULT_MAX_LEDS = 256;

    localparam int PIXEL_W   = 24;
    localparam int PH_CNT_W  = 14;
    localparam int BITS_W    = 5;
    localparam int SUM_W     = 10;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [BITS_W-1:0] BITS_PER_PIXEL = 5'd24;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_LED_COUNT   = 2'd0;
    localparam logic [1:0] REG_LONG_TICKS  = 2'd1;
    localparam logic [1:0] REG_SHORT_TICKS = 2'd2;
    localparam logic [1:0] REG_LATCH_TICKS = 2'd3;

    localparam logic [8:0]  LED_COUNT_RST   = 9'd12;
    localparam logic [7:0]  LONG_TICKS_RST  = 8'd120;
    localparam logic [7:0]  SHORT_TICKS_RST = 8'd35;
    localparam logic [13:0] LATCH_TICKS_RST = 14'd10000;

    // Operation codes of an input item.
    localparam logic [1:0] OP_FILL  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_FILL,
        CS_START
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] start_index;
        logic [8:0] pixel_count;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
    } result_t;

    typedef struct packed {
        logic fill_load;
        logic fill_step;
        logic frame_load;
        logic tick;
    } cmd_t;

    typedef struct packed {
        logic fill_done;
        logic phase_idle;
        logic line_level;
        logic busy;
    } status_t;

    // A programmed length of zero is stretched to one tick.
    function automatic logic [PH_CNT_W-1:0] at_least_one(input logic [PH_CNT_W-1:0] v);
        logic [PH_CNT_W-1:0] r;
        r = (v == '0) ? {{(PH_CNT_W-1){1'b0}}, 1'b1} : v;
        return r;
    endfunction

endpackage

// ----- design/addressable_led_serial_encoder.sv -----
// Single-wire addressable LED driver. Input items arrive on item_valid/item_stall/item_data
// and each produces exactly one result on result_valid/result_stall/result_data, in order.
// A fill item paints a range of the pixel store with one colour, a start item begins
// sending the stored frame, and a tick item advances the serial waveform by one clock.
// Tick items, rejected items and unknown operations are taken one per cycle while the
// receiver does not stall, and their result appears in the cycle after acceptance. A
// start item passes through a start state, as the first pixel must first be read from the
// pixel store. A fill item paints its pixels one at a time in a fill state, since the store
// has a single write port. The pixel store is cleared after reset by a pass that writes one
// entry a cycle; the first item is taken only once all MAX_LEDS entries are written, while
// configuration writes are taken as ever. The configuration registers return to their
// documented defaults at reset. The user is to write configuration through the APB-style
// port only while the block is idle; the block itself does not enforce this. A result
// waits in the output register while the receiver stalls; the next item is accepted only
// once that result has been taken or is being taken in the same cycle.
module addressable_led_serial_encoder #(
    parameter int MAX_LEDS = aled_pkg::DEFAULT_MAX_LEDS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  aled_pkg::item_t               item_data,
    output logic                          result_valid,
    input  logic                          result_stall,
    output aled_pkg::result_t             result_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aled_pkg::PADDR_W-1:0]  paddr,
    input  logic [aled_pkg::PDATA_W-1:0]  pwdata,
    output logic [aled_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    // Configuration registers, written on the access phase of an APB write.
    logic [8:0]                     led_count_reg;
    logic [7:0]                     long_ticks_reg;
    logic [7:0]                     short_ticks_reg;
    logic [aled_pkg::PH_CNT_W-1:0]  latch_ticks_reg;
    logic                           cfg_write;
    logic [1:0]                     reg_index;

    aled_pkg::cmd_t    cmd;
    aled_pkg::status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg   <= aled_pkg::LED_COUNT_RST;
            long_ticks_reg  <= aled_pkg::LONG_TICKS_RST;
            short_ticks_reg <= aled_pkg::SHORT_TICKS_RST;
            latch_ticks_reg <= aled_pkg::LATCH_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                aled_pkg::REG_LED_COUNT:   led_count_reg   <= pwdata[8:0];
                aled_pkg::REG_LONG_TICKS:  long_ticks_reg  <= pwdata[7:0];
                aled_pkg::REG_SHORT_TICKS: short_ticks_reg <= pwdata[7:0];
                aled_pkg::REG_LATCH_TICKS: latch_ticks_reg <= pwdata[aled_pkg::PH_CNT_W-1:0];
                default:                   led_count_reg   <= led_count_reg;
            endcase
        end
    end

    // Reads return the register zero-extended to the bus width.
    always_comb
    begin
        unique case (reg_index)
            aled_pkg::REG_LED_COUNT:   prdata = aled_pkg::PDATA_W'(led_count_reg);
            aled_pkg::REG_LONG_TICKS:  prdata = aled_pkg::PDATA_W'(long_ticks_reg);
            aled_pkg::REG_SHORT_TICKS: prdata = aled_pkg::PDATA_W'(short_ticks_reg);
            aled_pkg::REG_LATCH_TICKS: prdata = aled_pkg::PDATA_W'(latch_ticks_reg);
            default:                   prdata = '0;
        endcase
    end

    // The controller owns the handshakes and the result register; the datapath
    // holds the pixel store, the fill sweep and the waveform generator.
    aled_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .operation    (item_data.operation),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_data  (result_data),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    aled_dp #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .item        (item_data),
        .led_count   (led_count_reg),
        .long_ticks  (long_ticks_reg),
        .short_ticks (short_ticks_reg),
        .latch_ticks (latch_ticks_reg)
    );

endmodule

// ----- design/aled_ram.sv -----
module aled_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/aled_ctrl.sv -----
module aled_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic [1:0]          operation,
    output logic                item_stall,
    output logic                result_valid,
    output aled_pkg::result_t   result_data,
    input  logic                result_stall,
    output aled_pkg::cmd_t      cmd,
    input  aled_pkg::status_t   status
);

    aled_pkg::ctrl_state_t state_reg, state_next;
    logic                  result_valid_reg, result_valid_next;
    aled_pkg::result_t     result_reg, result_next;
    logic                  slot_free;
    logic                  accept;
    logic                  emit;
    logic                  emit_acc;

    // The result slot is free when empty or being emptied in this cycle.
    assign slot_free  = !result_valid_reg || !result_stall;
    assign item_stall = (state_reg != aled_pkg::CS_IDLE) || !slot_free;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= aled_pkg::CS_CLEAR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        emit       = 1'b0;
        emit_acc   = 1'b0;
        unique case (state_reg)
            aled_pkg::CS_CLEAR:
            begin
                if (status.fill_done)
                begin
                    state_next = aled_pkg::CS_IDLE;
                end
                else
                begin
                    cmd.fill_step = 1'b1;
                end
            end
            aled_pkg::CS_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        aled_pkg::OP_FILL:
                        begin
                            if (status.phase_idle)
                            begin
                                cmd.fill_load = 1'b1;
                                state_next    = aled_pkg::CS_FILL;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        aled_pkg::OP_START:
                        begin
                            if (status.phase_idle)
                            begin
                                state_next = aled_pkg::CS_START;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        aled_pkg::OP_TICK:
                        begin
                            cmd.tick = 1'b1;
                            emit     = 1'b1;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            aled_pkg::CS_FILL:
            begin
                if (!status.fill_done)
                begin
                    cmd.fill_step = 1'b1;
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_acc   = 1'b1;
                    state_next = aled_pkg::CS_IDLE;
                end
            end
            aled_pkg::CS_START:
            begin
                if (slot_free)
                begin
                    cmd.frame_load = 1'b1;
                    emit           = 1'b1;
                    emit_acc       = 1'b1;
                    state_next     = aled_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = aled_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        if (emit)
        begin
            result_valid_next      = 1'b1;
            result_next.line_level = status.line_level;
            result_next.busy_res   = status.busy;
            result_next.accepted   = emit_acc;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

// ----- design/aled_dp.sv -----
module aled_dp #(
    parameter int MAX_LEDS = aled_pkg::DEFAULT_MAX_LEDS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  aled_pkg::cmd_t                 cmd,
    output aled_pkg::status_t              status,
    input  aled_pkg::item_t                item,
    input  logic [8:0]                     led_count,
    input  logic [7:0]                     long_ticks,
    input  logic [7:0]                     short_ticks,
    input  logic [aled_pkg::PH_CNT_W-1:0]  latch_ticks
);

    localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W = $clog2(MAX_LEDS + 1);
    localparam int CW    = (CNT_W > aled_pkg::SUM_W) ? CNT_W : aled_pkg::SUM_W;
    localparam int PW    = aled_pkg::PIXEL_W;
    localparam int KW    = aled_pkg::PH_CNT_W;
    localparam int BW    = aled_pkg::BITS_W;

    // Range sweep used both for the clearing pass and for fills.
    logic [CW-1:0]  cur_reg, cur_next;
    logic [CW-1:0]  end_reg, end_next;
    logic [PW-1:0]  colour_reg, colour_next;

    aled_pkg::phase_t phase_reg, phase_next;
    logic [KW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  ptr_reg, ptr_next;
    logic [PW-1:0]  shift_reg, shift_next;
    logic [BW-1:0]  bits_reg, bits_next;

    logic [CW-1:0]  eff_count;
    logic [CW-1:0]  fill_sum;
    logic [CW-1:0]  ptr_inc;
    logic [KW-1:0]  cnt_dec;
    logic [PW-1:0]  shifted;
    logic [BW-1:0]  bits_dec;
    logic           do_load;
    logic [CW-1:0]  load_ptr;

    logic           wr_en;
    logic [AW-1:0]  rd_addr;
    logic [PW-1:0]  rd_data;

    assign eff_count = (CW'(led_count) > CW'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(led_count);
    assign fill_sum  = CW'(item.start_index) + CW'(item.pixel_count);
    assign ptr_inc   = ptr_reg + CW'(1);
    assign cnt_dec   = (cnt_reg != '0) ? cnt_reg - KW'(1) : cnt_reg;
    assign shifted   = {shift_reg[PW-2:0], 1'b0};
    assign bits_dec  = (bits_reg != '0) ? bits_reg - BW'(1) : bits_reg;

    // Reads run one pixel ahead of the word being shifted out, so the
    // next pixel is waiting when the last bit of the current one ends.
    assign rd_addr = (phase_reg == aled_pkg::PH_IDLE) ? '0 : ptr_inc[AW-1:0];
    assign wr_en   = cmd.fill_step;

    aled_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_reg[AW-1:0]),
        .wr_data (colour_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            end_reg    <= CW'(MAX_LEDS);
            colour_reg <= '0;
            phase_reg  <= aled_pkg::PH_IDLE;
            cnt_reg    <= '0;
            ptr_reg    <= '0;
            shift_reg  <= '0;
            bits_reg   <= '0;
        end
        else
        begin
            cur_reg    <= cur_next;
            end_reg    <= end_next;
            colour_reg <= colour_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            ptr_reg    <= ptr_next;
            shift_reg  <= shift_next;
            bits_reg   <= bits_next;
        end
    end

    always_comb
    begin
        cur_next    = cur_reg;
        end_next    = end_reg;
        colour_next = colour_reg;
        if (cmd.fill_load)
        begin
            cur_next    = CW'(item.start_index);
            end_next    = (fill_sum > eff_count) ? eff_count : fill_sum;
            colour_next = {item.green, item.red, item.blue};
        end
        else if (cmd.fill_step)
        begin
            cur_next = cur_reg + CW'(1);
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        do_load    = 1'b0;
        load_ptr   = '0;
        if (cmd.frame_load)
        begin
            do_load = 1'b1;
        end
        else if (cmd.tick && (phase_reg != aled_pkg::PH_IDLE))
        begin
            cnt_next = cnt_dec;
            if (cnt_dec == '0)
            begin
                case (phase_reg)
                    aled_pkg::PH_HIGH:
                    begin
                        phase_next = aled_pkg::PH_LOW;
                        cnt_next   = aled_pkg::at_least_one(
                            KW'(shift_reg[PW-1] ? short_ticks : long_ticks));
                    end
                    aled_pkg::PH_LOW:
                    begin
                        shift_next = shifted;
                        bits_next  = bits_dec;
                        if (bits_dec != '0)
                        begin
                            phase_next = aled_pkg::PH_HIGH;
                            cnt_next   = aled_pkg::at_least_one(
                                KW'(shifted[PW-1] ? long_ticks : short_ticks));
                        end
                        else
                        begin
                            do_load  = 1'b1;
                            load_ptr = ptr_inc;
                        end
                    end
                    aled_pkg::PH_LATCH:
                    begin
                        phase_next = aled_pkg::PH_IDLE;
                        cnt_next   = '0;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (do_load)
        begin
            ptr_next = load_ptr;
            if (load_ptr < eff_count)
            begin
                shift_next = rd_data;
                bits_next  = aled_pkg::BITS_PER_PIXEL;
                phase_next = aled_pkg::PH_HIGH;
                cnt_next   = aled_pkg::at_least_one(
                    KW'(rd_data[PW-1] ? long_ticks : short_ticks));
            end
            else
            begin
                bits_next  = '0;
                phase_next = aled_pkg::PH_LATCH;
                cnt_next   = aled_pkg::at_least_one(latch_ticks);
            end
        end
    end

    assign status.fill_done  = (cur_reg >= end_reg);
    assign status.phase_idle = (phase_reg == aled_pkg::PH_IDLE);
    assign status.line_level = (phase_next == aled_pkg::PH_HIGH);
    assign status.busy       = (phase_next != aled_pkg::PH_IDLE);

endmodule

// ----- tb/addressable_led_serial_encoder_tb.sv -----
`timescale 1ns / 100ps

module addressable_led_serial_encoder_tb;

    // The pixel store of the block under test is built with its default size.
    localparam int LED_SLOTS = aled_pkg::DEFAULT_MAX_LEDS;

    // The one operation code that the block does not define; it must be ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           item_valid;
    logic                           item_stall;
    aled_pkg::item_t                item_data;
    logic                           result_valid;
    logic                           result_stall;
    aled_pkg::result_t              result_data;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [aled_pkg::PADDR_W-1:0]   paddr;
    logic [aled_pkg::PDATA_W-1:0]   pwdata;
    logic [aled_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    // Our own picture of the strip: the stored colours (G:R:B), the position in the
    // frame being sent and the current phase of the line.
    logic [23:0]          px_colour [LED_SLOTS];
    logic [8:0]           tx_pixel;
    logic [23:0]          tx_word;
    logic [4:0]           tx_bits;
    logic [13:0]          tx_ticks;
    aled_pkg::phase_t     tx_phase;

    // Shadow copies of the configuration registers.
    logic [8:0]           cfg_leds;
    logic [7:0]           cfg_long;
    logic [7:0]           cfg_short;
    logic [13:0]          cfg_latch;

    // Line levels and flags still owed by the block, oldest first.
    aled_pkg::result_t    line_forecast [$];

    bit                   item_took_effect;
    int                   effective_items;
    int                   mismatches;
    bit                   quiet_run;
    int                   stall_left;

    addressable_led_serial_encoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // A hard ceiling on the run. The slowest legal run, with every item meeting the
    // longest gap and the longest stall, stays well inside this.
    initial
    begin
        #100_000_000;
        $display("addressable_led_serial_encoder_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction of the serial waveform
    // ------------------------------------------------------------------

    // A programmed phase length of zero behaves as a single tick.
    function automatic logic [13:0] stretch_ticks(input logic [13:0] v);
        return (v == '0) ? 14'd1 : v;
    endfunction

    // LEDs actually stored and sent: anything beyond the store is clipped.
    function automatic logic [8:0] leds_in_use();
        return (cfg_leds > LED_SLOTS) ? 9'(LED_SLOTS) : cfg_leds;
    endfunction

    // The high part of a bit is long for a one and short for a zero.
    function automatic void begin_bit_high();
        tx_phase = aled_pkg::PH_HIGH;
        tx_ticks = stretch_ticks(tx_word[23] ? {6'd0, cfg_long} : {6'd0, cfg_short});
    endfunction

    function automatic void begin_latch_low();
        tx_phase = aled_pkg::PH_LATCH;
        tx_ticks = stretch_ticks(cfg_latch);
    endfunction

    // Fetch the next pixel of the frame, or hold the line low once all are out.
    function automatic void load_next_pixel();
        if (tx_pixel < leds_in_use())
        begin
            tx_word = px_colour[tx_pixel[7:0]];
            tx_bits = 5'd24;
            begin_bit_high();
        end
        else
        begin
            tx_bits = '0;
            begin_latch_low();
        end
    endfunction

    // One clock of the waveform. When a phase runs out, the next one starts on
    // the same tick, so a phase of N ticks shows on N consecutive results.
    function automatic void advance_waveform();
        if (tx_phase == aled_pkg::PH_IDLE)
            return;
        if (tx_ticks != '0)
            tx_ticks--;
        if (tx_ticks != '0)
            return;
        case (tx_phase)
            aled_pkg::PH_HIGH:
            begin
                tx_phase = aled_pkg::PH_LOW;
                tx_ticks = stretch_ticks(tx_word[23] ? {6'd0, cfg_short} : {6'd0, cfg_long});
            end
            aled_pkg::PH_LOW:
            begin
                tx_word = tx_word << 1;
                if (tx_bits != '0)
                    tx_bits--;
                if (tx_bits != '0)
                    begin_bit_high();
                else
                begin
                    tx_pixel++;
                    load_next_pixel();
                end
            end
            default:
            begin
                tx_phase = aled_pkg::PH_IDLE;
                tx_ticks = '0;
            end
        endcase
    endfunction

    // Work out the result of one accepted item and move our picture of the block on.
    function automatic aled_pkg::result_t predict_line(input aled_pkg::item_t it);
        aled_pkg::result_t r;
        int                fill_end;
        int                i;
        logic              took;
        took = 1'b0;
        item_took_effect = 1'b0;
        case (it.operation)
            aled_pkg::OP_FILL:
                if (tx_phase == aled_pkg::PH_IDLE)
                begin
                    // The end is formed wide, so a range running past the strip is
                    // simply clipped rather than wrapping round.
                    fill_end = int'(it.start_index) + int'(it.pixel_count);
                    if (fill_end > int'(leds_in_use()))
                        fill_end = int'(leds_in_use());
                    for (i = int'(it.start_index); i < fill_end; i++)
                        px_colour[i] = {it.green, it.red, it.blue};
                    took = 1'b1;
                end
            aled_pkg::OP_START:
                if (tx_phase == aled_pkg::PH_IDLE)
                begin
                    tx_pixel = '0;
                    load_next_pixel();
                    took = 1'b1;
                end
            aled_pkg::OP_TICK:
            begin
                item_took_effect = (tx_phase != aled_pkg::PH_IDLE);
                advance_waveform();
            end
            default:
                ;
        endcase
        if (took)
            item_took_effect = 1'b1;
        r.line_level = (tx_phase == aled_pkg::PH_HIGH);
        r.busy_res   = (tx_phase != aled_pkg::PH_IDLE);
        r.accepted   = took;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------

    function automatic aled_pkg::item_t make_item(input logic [1:0] op,
                                                  input logic [7:0] first,
                                                  input logic [8:0] count,
                                                  input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
        aled_pkg::item_t it;
        it.operation   = op;
        it.start_index = first;
        it.pixel_count = count;
        it.red         = r;
        it.green       = g;
        it.blue        = b;
        return it;
    endfunction

    // Random content for every field; the operation is chosen by the caller.
    function automatic aled_pkg::item_t random_item(input logic [1:0] op);
        return make_item(op, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 256)),
                         8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Presents one item, now and then after a random gap, and holds it until the
    // block takes it. The expected result is queued at the edge of acceptance.
    task automatic send_item(input aled_pkg::item_t it);
        int gap;
        @(negedge clk);
        if (!quiet_run && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid = 1'b1;
        item_data  = it;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
                break;
        end
        line_forecast.push_back(predict_line(it));
        if (item_took_effect)
            effective_items++;
    endtask

    // Stop sending and wait until the block has answered every item so far.
    task automatic drain();
        @(negedge clk);
        item_valid = 1'b0;
        while (line_forecast.size() != 0)
            @(posedge clk);
    endtask

    // Tick the frame through to its end. With noise set, roughly one item in that
    // many is some other operation, which a busy block has to ignore.
    task automatic finish_frame(input int noise_one_in);
        aled_pkg::item_t it;
        while (tx_phase != aled_pkg::PH_IDLE)
        begin
            if (noise_one_in > 0 && $urandom_range(1, noise_one_in) == 1)
                it = random_item(2'($urandom_range(0, 3)));
            else
                it = random_item(aled_pkg::OP_TICK);
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver stalls in bursts, except in the quiet stretch at the end.
    initial
    begin
        result_stall = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall = 1'b1;
            end
            else if (!quiet_run && $urandom_range(0, 9) == 0)
            begin
                stall_left   = $urandom_range(1, 12) - 1;
                result_stall = 1'b1;
            end
            else
                result_stall = 1'b0;
        end
    end

    // Every result taken is held against the oldest expectation.
    always @(posedge clk)
    begin
        aled_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (line_forecast.size() == 0)
            begin
                $error("result with no item outstanding: %b", result_data);
                mismatches++;
            end
            else
            begin
                want = line_forecast.pop_front();
                if (result_data.line_level !== want.line_level)
                begin
                    $error("line_level: expected %0b, got %0b",
                           want.line_level, result_data.line_level);
                    mismatches++;
                end
                if (result_data.busy_res !== want.busy_res)
                begin
                    $error("busy_res: expected %0b, got %0b",
                           want.busy_res, result_data.busy_res);
                    mismatches++;
                end
                if (result_data.accepted !== want.accepted)
                begin
                    $error("accepted: expected %0b, got %0b",
                           want.accepted, result_data.accepted);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // A setup phase and then an access phase; the access completes on pready.
    task automatic apb_access(input logic [1:0] idx, input bit wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [31:0] reg_shadow(input logic [1:0] idx);
        case (idx)
            aled_pkg::REG_LED_COUNT:   return {23'd0, cfg_leds};
            aled_pkg::REG_LONG_TICKS:  return {24'd0, cfg_long};
            aled_pkg::REG_SHORT_TICKS: return {24'd0, cfg_short};
            default:                   return {18'd0, cfg_latch};
        endcase
    endfunction

    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] rd;
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== reg_shadow(idx))
        begin
            $error("register %0d: expected %0h, got %0h", idx, reg_shadow(idx), rd);
            mismatches++;
        end
    endtask

    // Writes one register, keeps the shadow in step and reads the value back.
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_access(idx, 1'b1, value, rd);
        case (idx)
            aled_pkg::REG_LED_COUNT:   cfg_leds  = value[8:0];
            aled_pkg::REG_LONG_TICKS:  cfg_long  = value[7:0];
            aled_pkg::REG_SHORT_TICKS: cfg_short = value[7:0];
            default:                   cfg_latch = value[13:0];
        endcase
        check_reg(idx);
    endtask

    // Only ever called with the block idle and nothing outstanding.
    task automatic set_timing(input int leds, input int long_len, input int short_len,
                              input int latch_len);
        set_reg(aled_pkg::REG_LED_COUNT, 32'(leds));
        set_reg(aled_pkg::REG_LONG_TICKS, 32'(long_len));
        set_reg(aled_pkg::REG_SHORT_TICKS, 32'(short_len));
        set_reg(aled_pkg::REG_LATCH_TICKS, 32'(latch_len));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The registers must come out of reset at their documented defaults.
    task automatic test_reset_values();
        check_reg(aled_pkg::REG_LED_COUNT);
        check_reg(aled_pkg::REG_LONG_TICKS);
        check_reg(aled_pkg::REG_SHORT_TICKS);
        check_reg(aled_pkg::REG_LATCH_TICKS);
    endtask

    // Field extremes and all operations but start at the default strip of twelve, then a
    // short frame with items thrown at the block while it is busy.
    task automatic test_fill_and_ignore();
        send_item(make_item(aled_pkg::OP_TICK, 8'hff, 9'h1ff, 8'hff, 8'hff, 8'hff));
        send_item(make_item(OP_UNUSED, 8'hff, 9'h1ff, 8'hff, 8'hff, 8'hff));
        send_item(make_item(aled_pkg::OP_FILL, 8'h00, 9'd0, 8'hff, 8'hff, 8'hff));
        send_item(make_item(aled_pkg::OP_FILL, 8'hff, 9'd256, 8'hff, 8'h00, 8'hff));
        send_item(make_item(aled_pkg::OP_FILL, 8'h00, 9'd256, 8'hff, 8'h00, 8'haa));
        send_item(make_item(aled_pkg::OP_FILL, 8'h01, 9'd1, 8'h00, 8'h5a, 8'h01));
        send_item(make_item(aled_pkg::OP_FILL, 8'h05, 9'd3, 8'h00, 8'hff, 8'h00));
        send_item(make_item(aled_pkg::OP_FILL, 8'h0b, 9'd1, 8'h80, 8'h80, 8'h80));
        drain();
        set_timing(2, 2, 1, 3);
        send_item(make_item(aled_pkg::OP_START, 8'h00, 9'd0, 8'h00, 8'h00, 8'h00));
        send_item(random_item(aled_pkg::OP_TICK));
        // Start and fill while busy must both be ignored.
        send_item(make_item(aled_pkg::OP_START, 8'hff, 9'h1ff, 8'hff, 8'hff, 8'hff));
        send_item(make_item(aled_pkg::OP_FILL, 8'h00, 9'd256, 8'h12, 8'h34, 8'h56));
        send_item(random_item(OP_UNUSED));
        send_item(random_item(aled_pkg::OP_TICK));
        finish_frame(0);
        send_item(random_item(aled_pkg::OP_TICK));
    endtask

    // Fills on a strip past the store size, and a frame with no LEDs at all.
    task automatic test_strip_length_extremes();
        drain();
        set_timing(511, 0, 0, 0);
        send_item(random_item(aled_pkg::OP_FILL));
        send_item(make_item(aled_pkg::OP_FILL, 8'h00, 9'd256, 8'($urandom), 8'($urandom),
                            8'($urandom)));
        send_item(make_item(aled_pkg::OP_FILL, 8'd200, 9'd256, 8'h0f, 8'hf0, 8'h3c));
        send_item(make_item(aled_pkg::OP_FILL, 8'hff, 9'd1, 8'hff, 8'hff, 8'hff));
        drain();
        set_timing(256, 1, 1, 1);
        send_item(make_item(aled_pkg::OP_FILL, 8'd250, 9'd256, 8'h55, 8'haa, 8'h55));
        drain();
        // With no LEDs a start goes straight to the latch time.
        set_timing(0, 3, 3, 2);
        send_item(make_item(aled_pkg::OP_FILL, 8'h00, 9'd5, 8'h11, 8'h22, 8'h33));
        send_item(make_item(aled_pkg::OP_START, 8'h00, 9'd0, 8'h00, 8'h00, 8'h00));
        finish_frame(0);
    endtask

    // The largest long and latch values are written and read back; frames on one LED
    // then run with zero-length phases and with a long latch time.
    task automatic test_phase_length_extremes();
        drain();
        set_timing(1, 255, 0, 16383);
        set_timing(1, 6, 0, 100);
        send_item(make_item(aled_pkg::OP_FILL, 8'h00, 9'd1, 8'h3c, 8'ha5, 8'h0f));
        send_item(make_item(aled_pkg::OP_START, 8'h00, 9'd0, 8'h00, 8'h00, 8'h00));
        finish_frame(0);
        drain();
        set_timing(1, 0, 6, 0);
        send_item(make_item(aled_pkg::OP_START, 8'h00, 9'd0, 8'h00, 8'h00, 8'h00));
        finish_frame(0);
    endtask

    // Mostly well-formed frames on short strips with short timings: a few fills, a
    // start and ticks to the end, with the odd stray item mixed in. Long strips get
    // fills only, so the frames stay cheap. The sender always waits for the block
    // to fall quiet before the timing is changed.
    task automatic test_random_frames(input int target);
        int              goal;
        int              leds;
        int              fills;
        int              n;
        aled_pkg::item_t it;
        goal = effective_items + target;
        while (effective_items < goal)
        begin
            drain();
            leds = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 511) : $urandom_range(0, 3);
            set_timing(leds, $urandom_range(0, 3), $urandom_range(0, 3),
                       $urandom_range(0, 6));
            fills = $urandom_range(1, 4);
            for (n = 0; n < fills; n++)
            begin
                it = random_item(aled_pkg::OP_FILL);
                if ($urandom_range(0, 1) == 0)
                    it.start_index = 8'($urandom_range(0, 3));
                if ($urandom_range(0, 3) != 0)
                    it.pixel_count = 9'($urandom_range(0, 4));
                send_item(it);
            end
            if ($urandom_range(0, 5) == 0)
                send_item(random_item(2'($urandom_range(2, 3))));
            if (leds <= 3)
            begin
                send_item(random_item(aled_pkg::OP_START));
                finish_frame(12);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        item_data       = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        quiet_run       = 1'b0;
        effective_items = 0;
        mismatches      = 0;
        for (int i = 0; i < LED_SLOTS; i++)
            px_colour[i] = '0;
        tx_pixel  = '0;
        tx_word   = '0;
        tx_bits   = '0;
        tx_ticks  = '0;
        tx_phase  = aled_pkg::PH_IDLE;
        cfg_leds  = aled_pkg::LED_COUNT_RST;
        cfg_long  = aled_pkg::LONG_TICKS_RST;
        cfg_short = aled_pkg::SHORT_TICKS_RST;
        cfg_latch = aled_pkg::LATCH_TICKS_RST;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_fill_and_ignore();
        test_strip_length_extremes();
        test_phase_length_extremes();
        test_random_frames(1050);
        // The closing stretch runs with neither side idling.
        quiet_run = 1'b1;
        test_random_frames(300);

        drain();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("addressable_led_serial_encoder_tb: done, clean");
        else
            $display("addressable_led_serial_encoder_tb: done, errors");
        $finish;
    end

endmodule
